FILE: src/packet_flow_key_extractor_macros.svh
// Assertion macros shared by the flow key extractor modules.
`ifndef PACKET_FLOW_KEY_EXTRACTOR_MACROS_SVH
`define PACKET_FLOW_KEY_EXTRACTOR_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PFKE_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define PFKE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: src/pfke_pkg.sv
// Package with constants, types and helpers for the flow key extractor.
package pfke_pkg;
  localparam int MaxVlanTagsDefault = 4;
  localparam int VlanTagBytes = 4;
  localparam int ResultBits = 4 + 1 + 8 + 16 + 16 + 16 + 64 * 4 + 16;
  // Result bus width, padded with zeros up to whole bytes.
  localparam int MDataBits = ((ResultBits + 7) / 8) * 8;

  localparam logic [2:0] STG_LINK = 3'd0;
  localparam logic [2:0] STG_IP4 = 3'd1;
  localparam logic [2:0] STG_IP6 = 3'd2;
  localparam logic [2:0] STG_L4 = 3'd3;
  localparam logic [2:0] STG_DONE = 3'd4;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_ARP = 4'd1;
  localparam logic [3:0] ST_LLDP = 4'd2;
  localparam logic [3:0] ST_OTHER = 4'd3;
  localparam logic [3:0] ST_BAD_IPLEN = 4'd4;
  localparam logic [3:0] ST_UNK_PROTO = 4'd5;
  localparam logic [3:0] ST_BAD_TCPLEN = 4'd6;
  localparam logic [3:0] ST_SLL_PROTO = 4'd7;
  localparam logic [3:0] ST_TRUNC = 4'd8;

  localparam logic [15:0] ETH_IP4 = 16'h0800;
  localparam logic [15:0] ETH_IP6 = 16'h86DD;
  localparam logic [15:0] ETH_VLAN = 16'h8100;
  localparam logic [15:0] ETH_ARP = 16'h0806;
  localparam logic [15:0] ETH_LLDP = 16'h88CC;

  localparam logic [7:0] PR_ICMP = 8'd1;
  localparam logic [7:0] PR_IGMP = 8'd2;
  localparam logic [7:0] PR_TCP = 8'd6;
  localparam logic [7:0] PR_UDP = 8'd17;
  localparam logic [7:0] PR_ESP = 8'd50;
  localparam logic [7:0] PR_ICMP6 = 8'd58;

  typedef struct packed {
    logic [7:0] data_byte;
    logic first_byte;
    logic last_byte;
    logic [15:0] wire_length;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] packet_bytes;
    logic [63:0] dst_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] src_addr_hi;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [15:0] ethertype_seen;
    logic [7:0] proto;
    logic is_ipv6;
    logic [3:0] status;
  } flow_key_t;

  function automatic logic proto_known(input logic [7:0] p, input logic ip6);
    return p == PR_ICMP || p == PR_IGMP || p == PR_TCP || p == PR_UDP ||
           p == PR_ESP || (ip6 && p == PR_ICMP6);
  endfunction
endpackage

FILE: src/pfke_parser.sv
// Per-packet parse state and header field capture, one byte per cycle while in_valid is high.
module pfke_parser import pfke_pkg::*; #(
  parameter int MAX_VLAN_TAGS = MaxVlanTagsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       link_type,
  input  logic       in_valid,
  input  byte_item_t in_item,
  output logic       key_valid,
  output flow_key_t  key
);
  localparam int VW = $clog2(MAX_VLAN_TAGS + 1);

  logic [7:0] byte_position, byte_position_next;
  logic [2:0] parse_stage, parse_stage_next;
  logic [VW-1:0] vlan_tags_seen, vlan_tags_seen_next;
  logic [7:0] network_start, network_start_next;
  logic [7:0] transport_start, transport_start_next;
  logic [15:0] type_shift, type_shift_next;
  logic [7:0] type_high, type_high_next;
  logic [7:0] proto_held, proto_held_next;
  logic [63:0] src_hi, src_hi_next, src_lo, src_lo_next;
  logic [63:0] dst_hi, dst_hi_next, dst_lo, dst_lo_next;
  logic [31:0] ports_held, ports_held_next;
  logic [31:0] icmp_held, icmp_held_next;
  logic [3:0] status_held, status_held_next;
  logic [15:0] length_held, length_held_next;

  always_comb begin
    logic [7:0] pos, off, b, stg_pos;
    logic [8:0] hi;
    logic [15:0] t;
    logic [7:0] ihl;
    logic brk;
    logic [7:0] it, ic;
    logic [15:0] id, sp, dp;
    logic enter;
    b = in_item.data_byte;
    byte_position_next = byte_position;
    parse_stage_next = parse_stage;
    vlan_tags_seen_next = vlan_tags_seen;
    network_start_next = network_start;
    transport_start_next = transport_start;
    type_shift_next = type_shift;
    type_high_next = type_high;
    proto_held_next = proto_held;
    src_hi_next = src_hi;
    src_lo_next = src_lo;
    dst_hi_next = dst_hi;
    dst_lo_next = dst_lo;
    ports_held_next = ports_held;
    icmp_held_next = icmp_held;
    status_held_next = status_held;
    length_held_next = length_held;
    if (in_item.first_byte) begin
      byte_position_next = '0;
      parse_stage_next = STG_LINK;
      vlan_tags_seen_next = '0;
      network_start_next = '0;
      transport_start_next = '0;
      type_shift_next = '0;
      type_high_next = '0;
      proto_held_next = '0;
      src_hi_next = '0;
      src_lo_next = '0;
      dst_hi_next = '0;
      dst_lo_next = '0;
      ports_held_next = '0;
      icmp_held_next = '0;
      status_held_next = ST_OK;
      length_held_next = in_item.wire_length;
    end
    pos = byte_position_next;
    stg_pos = 8'(pos + 8'd1);
    hi = link_type ? 9'd14 : 9'(9'd12 + 9'(VlanTagBytes) * 9'(vlan_tags_seen_next));
    t = {type_high_next, b};
    off = 8'(pos - network_start_next);
    ihl = {2'b00, b[3:0], 2'b00};
    brk = 1'b0;
    enter = 1'b0;
    it = icmp_held_next[15:8];
    ic = icmp_held_next[7:0];
    id = {8'h00, b};
    sp = '0;
    dp = '0;
    unique case (parse_stage_next)
      STG_LINK: begin
        if ({1'b0, pos} == hi) begin
          type_high_next = b;
        end else if ({1'b0, pos} == 9'(hi + 9'd1)) begin
          type_shift_next = t;
          network_start_next = stg_pos;
          if (t == ETH_IP4) begin
            parse_stage_next = STG_IP4;
          end else if (t == ETH_IP6) begin
            parse_stage_next = STG_IP6;
          end else if (link_type) begin
            status_held_next = ST_SLL_PROTO;
            parse_stage_next = STG_DONE;
          end else if (t == ETH_VLAN) begin
            if (VW'(vlan_tags_seen_next) < VW'(MAX_VLAN_TAGS)) begin
              vlan_tags_seen_next = VW'(vlan_tags_seen_next + 1'b1);
            end else begin
              status_held_next = ST_OTHER;
              parse_stage_next = STG_DONE;
            end
          end else begin
            parse_stage_next = STG_DONE;
            if (t == ETH_ARP) status_held_next = ST_ARP;
            else if (t == ETH_LLDP) status_held_next = ST_LLDP;
            else status_held_next = ST_OTHER;
          end
        end
      end
      STG_IP4: begin
        if (off == 8'd0) begin
          if (ihl < 8'd20) begin
            status_held_next = ST_BAD_IPLEN;
            parse_stage_next = STG_DONE;
            brk = 1'b1;
          end else begin
            transport_start_next = 8'(network_start_next + ihl);
          end
        end else if (off == 8'd9) begin
          proto_held_next = b;
          if (!proto_known(b, 1'b0)) begin
            status_held_next = ST_UNK_PROTO;
            parse_stage_next = STG_DONE;
            brk = 1'b1;
          end
        end else if (off >= 8'd12 && off <= 8'd15) begin
          src_lo_next = {32'h0, src_lo_next[23:0], b};
        end else if (off >= 8'd16 && off <= 8'd19) begin
          dst_lo_next = {32'h0, dst_lo_next[23:0], b};
        end
        if (!brk && off >= 8'd19 && stg_pos == transport_start_next) enter = 1'b1;
      end
      STG_IP6: begin
        if (off == 8'd6) begin
          proto_held_next = b;
          if (!proto_known(b, 1'b1)) begin
            status_held_next = ST_UNK_PROTO;
            parse_stage_next = STG_DONE;
          end
        end else if (off >= 8'd8 && off <= 8'd15) begin
          src_hi_next = {src_hi_next[55:0], b};
        end else if (off >= 8'd16 && off <= 8'd23) begin
          src_lo_next = {src_lo_next[55:0], b};
        end else if (off >= 8'd24 && off <= 8'd31) begin
          dst_hi_next = {dst_hi_next[55:0], b};
        end else if (off >= 8'd32 && off <= 8'd39) begin
          dst_lo_next = {dst_lo_next[55:0], b};
        end
        if (off == 8'd39) begin
          transport_start_next = 8'(network_start_next + 8'd40);
          enter = 1'b1;
        end
      end
      STG_L4: begin
        off = 8'(pos - transport_start_next);
        if (proto_held_next == PR_ICMP) begin
          if (off == 8'd0 || off == 8'd1 || off == 8'd4 || off == 8'd5)
            icmp_held_next = {icmp_held_next[23:0], b};
          if (off == 8'd5) begin
            it = icmp_held_next[31:24];
            ic = icmp_held_next[23:16];
            id = icmp_held_next[15:0];
            if (it == 8'd8) begin
              dp = {8'h08, ic};
              sp = id;
            end else if (it == 8'd0) begin
              sp = {8'h08, ic};
              dp = id;
            end else begin
              sp = {8'h00, it};
              dp = {id[7:0], id[15:8]};
            end
            ports_held_next = {sp, dp};
            status_held_next = ST_OK;
            parse_stage_next = STG_DONE;
          end
        end else begin
          if (off <= 8'd3) ports_held_next = {ports_held_next[23:0], b};
          if (proto_held_next == PR_UDP && off == 8'd3) begin
            status_held_next = ST_OK;
            parse_stage_next = STG_DONE;
          end else if (proto_held_next == PR_TCP && off == 8'd12) begin
            status_held_next = (b[7:4] < 4'd5) ? ST_BAD_TCPLEN : ST_OK;
            parse_stage_next = STG_DONE;
          end
        end
      end
      default: ;
    endcase
    if (enter) begin
      if (proto_held_next == PR_IGMP || proto_held_next == PR_ICMP6 ||
          proto_held_next == PR_ESP) begin
        ports_held_next = '0;
        status_held_next = ST_OK;
        parse_stage_next = STG_DONE;
      end else begin
        parse_stage_next = STG_L4;
      end
    end
    if (pos != 8'hFF) byte_position_next = 8'(pos + 8'd1);
    if (in_item.last_byte && parse_stage_next != STG_DONE) begin
      status_held_next = ST_TRUNC;
    end
  end

  always_comb begin
    logic ok;
    ok = status_held_next == ST_OK;
    key.status = status_held_next;
    key.is_ipv6 = type_shift_next == ETH_IP6;
    key.proto = proto_held_next;
    key.ethertype_seen = type_shift_next;
    key.src_port = ok ? ports_held_next[31:16] : '0;
    key.dst_port = ok ? ports_held_next[15:0] : '0;
    key.src_addr_hi = ok ? src_hi_next : '0;
    key.src_addr_lo = ok ? src_lo_next : '0;
    key.dst_addr_hi = ok ? dst_hi_next : '0;
    key.dst_addr_lo = ok ? dst_lo_next : '0;
    key.packet_bytes = length_held_next;
    key_valid = in_valid && in_item.last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      parse_stage <= STG_LINK;
      vlan_tags_seen <= '0;
      network_start <= '0;
      transport_start <= '0;
      type_shift <= '0;
      type_high <= '0;
      proto_held <= '0;
      src_hi <= '0;
      src_lo <= '0;
      dst_hi <= '0;
      dst_lo <= '0;
      ports_held <= '0;
      icmp_held <= '0;
      status_held <= ST_OK;
      length_held <= '0;
    end else if (in_valid) begin
      if (in_item.last_byte) begin
        byte_position <= '0;
        parse_stage <= STG_LINK;
        vlan_tags_seen <= '0;
        network_start <= '0;
        transport_start <= '0;
        type_shift <= '0;
        type_high <= '0;
        proto_held <= '0;
        src_hi <= '0;
        src_lo <= '0;
        dst_hi <= '0;
        dst_lo <= '0;
        ports_held <= '0;
        icmp_held <= '0;
        status_held <= ST_OK;
      end else begin
        byte_position <= byte_position_next;
        parse_stage <= parse_stage_next;
        vlan_tags_seen <= vlan_tags_seen_next;
        network_start <= network_start_next;
        transport_start <= transport_start_next;
        type_shift <= type_shift_next;
        type_high <= type_high_next;
        proto_held <= proto_held_next;
        src_hi <= src_hi_next;
        src_lo <= src_lo_next;
        dst_hi <= dst_hi_next;
        dst_lo <= dst_lo_next;
        ports_held <= ports_held_next;
        icmp_held <= icmp_held_next;
        status_held <= status_held_next;
      end
      length_held <= length_held_next;
    end
  end

  `include "packet_flow_key_extractor_macros.svh"
  `PFKE_ASSERT_IMP(a_stage_range, clk, rst, 1'b1, parse_stage <= STG_DONE,
    "parse stage out of range")
  `PFKE_ASSERT_IMP(a_vlan_bound, clk, rst, 1'b1,
    32'(vlan_tags_seen) <= MAX_VLAN_TAGS, "vlan count over bound")
  `PFKE_ASSERT_NEXT(a_clear_after_last, clk, rst, in_valid && in_item.last_byte,
    parse_stage == STG_LINK && byte_position == 8'd0, "state not cleared after last byte")
endmodule

FILE: src/pfke_out_reg.sv
// Output register with skid stage for flow key results.
module pfke_out_reg import pfke_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  flow_key_t in_key,
  output logic      out_valid,
  input  logic      out_ready,
  output flow_key_t out_key
);
  logic skid_valid;
  flow_key_t skid_key;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_valid) begin
          out_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_valid;
        end
      end else if (in_valid && !skid_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_key <= skid_valid ? skid_key : in_key;
    end else if (in_valid && !skid_valid) begin
      skid_key <= in_key;
    end
  end

  `include "packet_flow_key_extractor_macros.svh"
  `PFKE_ASSERT_IMP(a_skid_needs_out, clk, rst, skid_valid, out_valid,
    "skid full while output empty")
  `PFKE_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && out_ready, out_valid,
    "skid entry lost")
  `PFKE_ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid,
    "stalled result dropped")
endmodule

FILE: src/packet_flow_key_extractor.sv
// Top level of the packet flow key extractor.
//
// The block takes one packet byte per s_axis transaction. s_axis_tdata holds
// data_byte and wire_length, s_axis_tuser marks the first byte, and
// s_axis_tlast marks the last captured byte. It parses Ethernet (with up to
// MAX_VLAN_TAGS tags) or SLL framing, then IPv4 or IPv6, then TCP, UDP,
// ICMP, IGMP, ICMPv6 or ESP, and on the last byte emits one flow key on
// m_axis. Bytes are taken at one per cycle while s_axis_tready is high. The
// key for a packet is formed from the parse state in the same cycle as
// the last byte is accepted, and is registered before it reaches m_axis.
// link_type selects the framing; write it while no packet is in flight.
// Reset clears the parse state, the framing register and the output stage.
// When the receiver stalls, one key waits in the output register and a
// second in a skid register; s_axis_tready drops only when both are full,
// so bytes keep flowing while just one key is pending.
module packet_flow_key_extractor import pfke_pkg::*; #(
  parameter int MAX_VLAN_TAGS = MaxVlanTagsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // data_byte[7:0], wire_length[23:8]
  input  logic         s_axis_tuser,   // first_byte
  input  logic         s_axis_tlast,   // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [MDataBits-1:0] m_axis_tdata // status, is_ipv6, proto,
  // ethertype_seen, src_port, dst_port, src_addr_hi, src_addr_lo,
  // dst_addr_hi, dst_addr_lo, packet_bytes (lowest bits first), zero padding
);
  logic link_type;
  logic in_ok;
  logic key_valid;
  logic out_in_ready;
  byte_item_t item;
  flow_key_t key, out_key;

  always_ff @(posedge clk) begin
    if (rst) link_type <= 1'b0;
    else if (cfg_we) link_type <= cfg_wdata;
  end

  assign item.data_byte = s_axis_tdata[7:0];
  assign item.wire_length = s_axis_tdata[23:8];
  assign item.first_byte = s_axis_tuser;
  assign item.last_byte = s_axis_tlast;

  // A byte is taken whenever the skid stage has room for a key.
  assign s_axis_tready = out_in_ready;
  assign in_ok = s_axis_tvalid && s_axis_tready;

  pfke_parser #(.MAX_VLAN_TAGS(MAX_VLAN_TAGS)) u_parser (
    .clk(clk), .rst(rst), .link_type(link_type), .in_valid(in_ok),
    .in_item(item), .key_valid(key_valid), .key(key)
  );

  pfke_out_reg u_out (
    .clk(clk), .rst(rst), .in_valid(key_valid), .in_ready(out_in_ready),
    .in_key(key), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_key(out_key)
  );

  // Flow key struct is declared last field first, so status sits at bit 0.
  // The bus is filled up to whole bytes with zeros above the key.
  assign m_axis_tdata = MDataBits'(out_key);
endmodule
